>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// Next-cycle implication, off while reset is high.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, pre, post) \
   label: assert property (@(posedge clk) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

>>> rtl/nsc_pkg.sv
// Shared constants, result type and decode functions for the sentence checker.
package nsc_pkg;

   localparam int MAX_SENTENCE_LEN = 128;
   localparam int POS_W            = $clog2(MAX_SENTENCE_LEN + 1);
   localparam int MIN_SENTENCE_LEN = 6;
   localparam int HEADER_LEN       = 5;
   localparam int STAR_TAIL        = 3;

   localparam logic [7:0] CHAR_DOLLAR      = 8'h24;
   localparam logic [7:0] CHAR_STAR        = 8'h2A;
   localparam logic [7:0] CHAR_A           = 8'h41;
   localparam logic [7:0] CHAR_ZERO        = 8'h30;
   localparam logic [7:0] HEX_ALPHA_OFFSET = 8'd55;

   localparam logic [2:0] KIND_GGA   = 3'd0;
   localparam logic [2:0] KIND_GLL   = 3'd1;
   localparam logic [2:0] KIND_GSA   = 3'd2;
   localparam logic [2:0] KIND_QSA   = 3'd3;
   localparam logic [2:0] KIND_GSV   = 3'd4;
   localparam logic [2:0] KIND_RMC   = 3'd5;
   localparam logic [2:0] KIND_VTG   = 3'd6;
   localparam logic [2:0] KIND_OTHER = 3'd7;

   // Packed lowest field last: ok sits in bit 0.
   typedef struct packed {
      logic [7:0] received_sum;
      logic [7:0] computed_sum;
      logic [2:0] last_good_kind;
      logic [2:0] sentence_kind;
      logic       sentence_ok;
   } nsc_result_type;

   function automatic logic [7:0] hex_digit(input logic [7:0] c);
      hex_digit = (c >= CHAR_A) ? (c - HEX_ALPHA_OFFSET) : (c - CHAR_ZERO);
   endfunction

   // Header holds byte 1 in its low bits; reverse so string literals read in order.
   function automatic logic [2:0] classify_header(input logic [39:0] header);
      logic [39:0] text;
      text = {header[7:0], header[15:8], header[23:16], header[31:24], header[39:32]};
      case (text)
         "GPGGA", "GNGGA", "BDGGA", "GLGGA", "GBGGA": classify_header = KIND_GGA;
         "GPGLL", "GNGLL", "BDGLL", "GLGLL", "GBGLL": classify_header = KIND_GLL;
         "GPGSA", "GNGSA", "BDGSA", "GLGSA", "GAGSA", "GBGSA":
            classify_header = KIND_GSA;
         "GPQSA", "QZQSA", "GBQSA": classify_header = KIND_QSA;
         "GPGSV", "QZGSV", "GLGSV", "GAGSV", "BDGSV", "GBGSV":
            classify_header = KIND_GSV;
         "GPRMC", "GNRMC", "BDRMC", "GLRMC", "GBRMC": classify_header = KIND_RMC;
         "GPVTG", "GNVTG", "BDVTG", "GLVTG", "GBVTG": classify_header = KIND_VTG;
         default: classify_header = KIND_OTHER;
      endcase
   endfunction

endpackage

>>> rtl/nsc_parser.sv
// Per-sentence state: running XOR, star tracking, checksum digits, header and verdict.
module nsc_parser
   import nsc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  logic [7:0]     char_in,
   input  logic           end_of_sentence,
   output nsc_result_type result
);

   logic [POS_W-1:0] byte_position_ff, byte_position_in;
   logic [7:0]       running_xor_ff, running_xor_in;
   logic [39:0]      header_bytes_ff, header_bytes_in;
   logic             dollar_seen_ff, dollar_seen_in;
   logic             star_seen_ff, star_seen_in;
   logic [POS_W-1:0] star_position_ff, star_position_in;
   logic [7:0]       hex_value_ff, hex_value_in;
   logic             high_bit_error_ff, high_bit_error_in;
   logic [2:0]       previous_kind_ff, previous_kind_in;

   logic             overflow;
   logic [POS_W:0]   sentence_len;
   logic [POS_W:0]   star_ext;
   logic [7:0]       digit;
   logic             ok;
   logic [2:0]       kind;

   assign overflow     = byte_position_ff >= POS_W'(MAX_SENTENCE_LEN);
   assign sentence_len = {1'b0, byte_position_ff} + (POS_W+1)'(1);
   assign digit        = hex_digit(char_in);

   always_comb begin
      byte_position_in  = byte_position_ff;
      running_xor_in    = running_xor_ff;
      header_bytes_in   = header_bytes_ff;
      dollar_seen_in    = dollar_seen_ff;
      star_seen_in      = star_seen_ff;
      star_position_in  = star_position_ff;
      hex_value_in      = hex_value_ff;
      high_bit_error_in = high_bit_error_ff;
      star_ext          = {1'b0, star_position_ff};
      if (!overflow) begin
         if (byte_position_ff == '0) begin
            dollar_seen_in = (char_in == CHAR_DOLLAR);
         end
         for (int k = 0; k < HEADER_LEN; k++) begin
            if (byte_position_ff == POS_W'(k + 1)) begin
               header_bytes_in[8*k +: 8] = header_bytes_ff[8*k +: 8] | char_in;
            end
         end
         if (byte_position_ff == POS_W'(1)) begin
            running_xor_in = char_in;
         end else if (byte_position_ff >= POS_W'(2)) begin
            if (star_seen_ff) begin
               if ({1'b0, byte_position_ff} == star_ext + (POS_W+1)'(1)) begin
                  hex_value_in = {digit[3:0], 4'b0000};
               end else if ({1'b0, byte_position_ff} == star_ext + (POS_W+1)'(2)) begin
                  hex_value_in = hex_value_ff + digit;
               end
            end else if (char_in == CHAR_STAR) begin
               star_seen_in     = 1'b1;
               star_position_in = byte_position_ff;
            end else begin
               running_xor_in = running_xor_ff ^ char_in;
               if (char_in[7]) begin
                  high_bit_error_in = 1'b1;
               end
            end
         end
         byte_position_in = sentence_len[POS_W-1:0];
      end

      ok = !overflow && (sentence_len >= (POS_W+1)'(MIN_SENTENCE_LEN)) && star_seen_in &&
           ({1'b0, star_position_in} + (POS_W+1)'(STAR_TAIL) <= sentence_len) &&
           !high_bit_error_in && (running_xor_in == hex_value_in);
      kind = (ok && dollar_seen_in) ? classify_header(header_bytes_in) : KIND_OTHER;
      previous_kind_in = ok ? kind : previous_kind_ff;

      result.sentence_ok    = ok;
      result.sentence_kind  = kind;
      result.last_good_kind = previous_kind_in;
      result.computed_sum   = running_xor_in;
      result.received_sum   = hex_value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff  <= '0;
         running_xor_ff    <= '0;
         header_bytes_ff   <= '0;
         dollar_seen_ff    <= 1'b0;
         star_seen_ff      <= 1'b0;
         star_position_ff  <= '0;
         hex_value_ff      <= '0;
         high_bit_error_ff <= 1'b0;
         previous_kind_ff  <= KIND_OTHER;
      end else if (step) begin
         if (end_of_sentence) begin
            // Drop per-sentence state, keep the last good kind.
            byte_position_ff  <= '0;
            running_xor_ff    <= '0;
            header_bytes_ff   <= '0;
            dollar_seen_ff    <= 1'b0;
            star_seen_ff      <= 1'b0;
            star_position_ff  <= '0;
            hex_value_ff      <= '0;
            high_bit_error_ff <= 1'b0;
            previous_kind_ff  <= previous_kind_in;
         end else begin
            byte_position_ff  <= byte_position_in;
            running_xor_ff    <= running_xor_in;
            header_bytes_ff   <= header_bytes_in;
            dollar_seen_ff    <= dollar_seen_in;
            star_seen_ff      <= star_seen_in;
            star_position_ff  <= star_position_in;
            hex_value_ff      <= hex_value_in;
            high_bit_error_ff <= high_bit_error_in;
         end
      end
   end

endmodule

>>> rtl/nmea_sentence_check_classify_core.sv
// Sentence checksum checker and classifier: input register, parser, result register.
// The result of a last byte is written into the result register and drives rsp from there.
// Throughput: one byte per cycle; a last byte waits only while an earlier result is unread.
// The input register and the result register part the two sides, so bytes keep flowing
// while a finished result waits.
// Reset (synchronous, active high) empties both registers, clears sentence state, kind 7.
module nmea_sentence_check_classify_core
   import nsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_in
   input  logic        req_tlast,   // end_of_sentence
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [0] sentence_ok, [3:1] sentence_kind,
                                    // [6:4] last_good_kind, [14:7] computed_sum,
                                    // [22:15] received_sum, [23] zero
);

   logic           in_valid_ff;
   logic [7:0]     in_char_ff;
   logic           in_last_ff;
   logic           rsp_valid_ff;
   nsc_result_type rsp_data_ff;

   logic           advance;
   nsc_result_type result;

   // A last byte advances only when the result register can take it.
   assign advance    = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   nsc_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .step            (advance),
      .char_in         (in_char_ff),
      .end_of_sentence (in_last_ff),
      .result          (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance && in_last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance && in_last_ff) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

endmodule

>>> rtl/nsc_checker.sv
// Port-level assertions for the sentence checker, bound to the top level.
`include "assert_macros.svh"

module nsc_checker
   import nsc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   `ASSERT_NEXT_ALWAYS(a_reset_empties, clock, reset, !rsp_tvalid)
   `ASSERT_NEXT(a_stall_holds, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `ASSERT_IMPLY(a_bad_is_other, clock, reset, rsp_tvalid && !rsp_tdata[0], rsp_tdata[3:1] == KIND_OTHER)
   `ASSERT_IMPLY(a_good_updates_kind, clock, reset, rsp_tvalid && rsp_tdata[0], rsp_tdata[6:4] == rsp_tdata[3:1])
   `ASSERT_IMPLY(a_good_sums_match, clock, reset, rsp_tvalid && rsp_tdata[0], rsp_tdata[14:7] == rsp_tdata[22:15])

endmodule

bind nmea_sentence_check_classify_core nsc_checker u_nsc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> test/tb_top.sv
// Testbench for the sentence checksum checker and classifier: directed and random sentences.
module tb_top;
   import nsc_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 400;
   localparam int RANDOM_BYTES = 1000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] char_in
   logic        req_tlast;   // end_of_sentence
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // [0] sentence_ok, [3:1] sentence_kind, [6:4] last_good_kind,
                             // [14:7] computed_sum, [22:15] received_sum, [23] zero

   nmea_sentence_check_classify_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Sentence tracking state, mirrors what the block holds between bytes.
   logic [7:0]  seen_count;
   logic [7:0]  xor_acc;
   logic [39:0] hdr_acc;
   logic        lead_dollar;
   logic        star_found;
   logic [7:0]  star_idx;
   logic [7:0]  rx_sum;
   logic        high_bit;
   logic [2:0]  last_kind;

   nsc_result_type pending_verdicts[$];
   logic [7:0]     sentence_bytes[$];
   nsc_result_type want;
   nsc_result_type got;
   int             failures = 0;
   int             cycle_count = 0;
   bit             tx_quiet = 1'b0;
   bit             rx_quiet = 1'b0;
   bit             hold_rsp = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void clear_sentence_state();
      seen_count  = '0;
      xor_acc     = '0;
      hdr_acc     = '0;
      lead_dollar = 1'b0;
      star_found  = 1'b0;
      star_idx    = '0;
      rx_sum      = '0;
      high_bit    = 1'b0;
   endfunction

   function automatic logic [7:0] digit_value(input logic [7:0] c);
      return (c >= CHAR_A) ? c - HEX_ALPHA_OFFSET : c - CHAR_ZERO;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] d);
      return (d < 4'd10) ? CHAR_ZERO + 8'(d) : HEX_ALPHA_OFFSET + 8'(d);
   endfunction

   // Split the header into talker and sentence code; each code allows its own talkers.
   function automatic logic [2:0] talker_sentence_kind(input logic [39:0] hdr);
      logic [15:0] talker;
      logic [23:0] code;
      logic [2:0]  kind;
      bit          common;
      bit          known;
      talker = {hdr[7:0], hdr[15:8]};
      code   = {hdr[23:16], hdr[31:24], hdr[39:32]};
      common = talker == "GP" || talker == "GN" || talker == "BD" ||
               talker == "GL" || talker == "GB";
      case (code)
         "GGA": kind = KIND_GGA;
         "GLL": kind = KIND_GLL;
         "GSA": kind = KIND_GSA;
         "QSA": kind = KIND_QSA;
         "GSV": kind = KIND_GSV;
         "RMC": kind = KIND_RMC;
         "VTG": kind = KIND_VTG;
         default: kind = KIND_OTHER;
      endcase
      case (kind)
         KIND_GSA: known = common || talker == "GA";
         KIND_QSA: known = talker == "GP" || talker == "QZ" || talker == "GB";
         KIND_GSV: known = (common && talker != "GN") || talker == "GA" || talker == "QZ";
         default:  known = common;
      endcase
      return known ? kind : KIND_OTHER;
   endfunction

   // Advance the sentence state by one byte; returns 1 with the verdict on the last byte.
   function automatic bit predict_nmea_byte(input logic [7:0] c, input bit last,
                                            output nsc_result_type verdict);
      int         idx;
      bit         past_end;
      bit         good;
      logic [7:0] d;
      logic [2:0] kind;
      idx      = seen_count;
      past_end = idx >= MAX_SENTENCE_LEN;
      verdict  = '0;
      if (!past_end) begin
         if (idx == 0)
            lead_dollar = c == CHAR_DOLLAR;
         if (idx >= 1 && idx <= HEADER_LEN)
            hdr_acc[8*(idx-1) +: 8] = c;
         if (idx == 1) begin
            xor_acc = c;
         end else if (idx >= 2) begin
            if (star_found) begin
               d = digit_value(c);
               if (idx == star_idx + 1)
                  rx_sum = {d[3:0], 4'h0};
               else if (idx == star_idx + 2)
                  rx_sum = rx_sum + d;
            end else if (c == CHAR_STAR) begin
               star_found = 1'b1;
               star_idx   = 8'(idx);
            end else begin
               xor_acc = xor_acc ^ c;
               if (c[7])
                  high_bit = 1'b1;
            end
         end
         seen_count = 8'(idx + 1);
      end
      if (!last)
         return 1'b0;
      good = !past_end && idx + 1 >= MIN_SENTENCE_LEN && star_found &&
             int'(star_idx) + STAR_TAIL <= idx + 1 && !high_bit && xor_acc == rx_sum;
      kind = (good && lead_dollar) ? talker_sentence_kind(hdr_acc) : KIND_OTHER;
      if (good)
         last_kind = kind;
      verdict.sentence_ok    = good;
      verdict.sentence_kind  = kind;
      verdict.last_good_kind = last_kind;
      verdict.computed_sum   = xor_acc;
      verdict.received_sum   = rx_sum;
      clear_sentence_state();
      return 1'b1;
   endfunction

   task automatic send_byte(input logic [7:0] c, input bit last);
      nsc_result_type verdict;
      @(negedge clock);
      if (!tx_quiet && $urandom_range(99) < 30) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      if (predict_nmea_byte(c, last, verdict))
         pending_verdicts.push_back(verdict);
   endtask

   task automatic send_sentence();
      for (int i = 0; i < sentence_bytes.size(); i++)
         send_byte(sentence_bytes[i], i == sentence_bytes.size() - 1);
   endtask

   task automatic start_sentence(input logic [7:0] lead, input logic [39:0] text);
      sentence_bytes.delete();
      sentence_bytes.push_back(lead);
      for (int i = 4; i >= 0; i--)
         sentence_bytes.push_back(text[8*i +: 8]);
   endtask

   task automatic add_body(input int len);
      logic [7:0] ch;
      repeat (len) begin
         ch = 8'($urandom_range(32, 126));
         if (ch == CHAR_STAR)
            ch = ",";
         sentence_bytes.push_back(ch);
      end
   endtask

   task automatic close_sentence();
      logic [7:0] sum;
      sum = '0;
      for (int i = 1; i < sentence_bytes.size(); i++)
         sum = sum ^ sentence_bytes[i];
      sentence_bytes.push_back(CHAR_STAR);
      sentence_bytes.push_back(hex_char(sum[7:4]));
      sentence_bytes.push_back(hex_char(sum[3:0]));
   endtask

   task automatic spoil_checksum();
      int last_idx;
      last_idx = sentence_bytes.size() - 1;
      sentence_bytes[last_idx] = (sentence_bytes[last_idx] == "0") ? "1" : "0";
   endtask

   task automatic lower_digits();
      for (int i = sentence_bytes.size() - 2; i < sentence_bytes.size(); i++)
         if (sentence_bytes[i] >= "A" && sentence_bytes[i] <= "F")
            sentence_bytes[i] = sentence_bytes[i] + 8'd32;
   endtask

   function automatic logic [39:0] random_header();
      logic [15:0] talker;
      logic [23:0] code;
      case ($urandom_range(7))
         0: talker = "GP";
         1: talker = "GN";
         2: talker = "BD";
         3: talker = "GL";
         4: talker = "GA";
         5: talker = "GB";
         6: talker = "QZ";
         default: talker = {8'($urandom_range(65, 90)), 8'($urandom_range(65, 90))};
      endcase
      case ($urandom_range(8))
         0: code = "GGA";
         1: code = "GLL";
         2: code = "GSA";
         3: code = "QSA";
         4: code = "GSV";
         5: code = "RMC";
         6: code = "VTG";
         default: code = {8'($urandom_range(65, 90)), 8'($urandom_range(65, 90)),
                          8'($urandom_range(65, 90))};
      endcase
      return {talker, code};
   endfunction

   task automatic test_sentence_kinds();
      logic [39:0] headers[10] = '{"GPGGA", "GNGLL", "GAGSA", "GBQSA", "QZGSV",
                                   "BDRMC", "GLVTG", "GNGSV", "QZGGA", "GPXYZ"};
      foreach (headers[i]) begin
         start_sentence(CHAR_DOLLAR, headers[i]);
         add_body($urandom_range(0, 12));
         close_sentence();
         send_sentence();
      end
   endtask

   task automatic test_corner_cases();
      int long_bodies[3] = '{119, 120, 191};
      // lone last byte
      sentence_bytes.delete();
      sentence_bytes.push_back(CHAR_DOLLAR);
      send_sentence();
      // five bytes: too short
      start_sentence(CHAR_DOLLAR, "GPGGA");
      void'(sentence_bytes.pop_back());
      send_sentence();
      // shortest good one: star right after the talker
      sentence_bytes.delete();
      sentence_bytes.push_back(CHAR_DOLLAR);
      sentence_bytes.push_back("G");
      sentence_bytes.push_back("P");
      close_sentence();
      send_sentence();
      // star in byte 1 is plain data
      start_sentence(CHAR_DOLLAR, "*GGA,");
      add_body(4);
      close_sentence();
      send_sentence();
      // no star at all
      start_sentence(CHAR_DOLLAR, "GPGLL");
      add_body(6);
      send_sentence();
      // star with a single digit after it
      start_sentence(CHAR_DOLLAR, "GPGLL");
      add_body(3);
      sentence_bytes.push_back(CHAR_STAR);
      sentence_bytes.push_back("4");
      send_sentence();
      // bit 7 in bytes 0 and 1 goes unchecked
      start_sentence(8'hFF, {8'h80, "PGGA"});
      add_body(4);
      close_sentence();
      send_sentence();
      // bit 7 in byte 2 spoils the sentence
      start_sentence(CHAR_DOLLAR, "GPRMC");
      sentence_bytes[2] = sentence_bytes[2] | 8'h80;
      add_body(3);
      close_sentence();
      send_sentence();
      // bytes past the two digits are ignored
      start_sentence(CHAR_DOLLAR, "GPVTG");
      add_body(2);
      close_sentence();
      sentence_bytes.push_back(8'hFF);
      sentence_bytes.push_back(8'h7F);
      send_sentence();
      // any byte decodes as a digit, wrapping
      start_sentence(CHAR_DOLLAR, "GPGSV");
      add_body(2);
      sentence_bytes.push_back(CHAR_STAR);
      sentence_bytes.push_back(8'h00);
      sentence_bytes.push_back(8'hFF);
      send_sentence();
      start_sentence(CHAR_DOLLAR, "GPGGA");
      add_body(5);
      close_sentence();
      lower_digits();
      send_sentence();
      start_sentence(CHAR_DOLLAR, "GPGGA");
      add_body(3);
      close_sentence();
      spoil_checksum();
      send_sentence();
      // good checksum without the leading dollar
      start_sentence("!", "GPGGA");
      add_body(3);
      close_sentence();
      send_sentence();
      // longest accepted, one byte over, and far past the position saturation
      foreach (long_bodies[i]) begin
         start_sentence(CHAR_DOLLAR, "GPRMC");
         add_body(long_bodies[i]);
         close_sentence();
         send_sentence();
      end
   endtask

   // Hold the result side while short sentences keep coming, so the input backs up.
   task automatic test_output_stall();
      tx_quiet = 1'b1;
      rx_quiet = 1'b1;
      hold_rsp = 1'b1;
      repeat (12) begin
         start_sentence(CHAR_DOLLAR, random_header());
         add_body($urandom_range(0, 2));
         close_sentence();
         send_sentence();
      end
      tx_quiet = 1'b0;
      rx_quiet = 1'b0;
   endtask

   task automatic test_random_traffic();
      int sent;
      int pick;
      int len;
      int p;
      sent = 0;
      while (sent < RANDOM_BYTES) begin
         tx_quiet = sent >= 400 && sent < 700;
         rx_quiet = tx_quiet;
         pick = $urandom_range(99);
         if (pick < 15) begin
            sentence_bytes.delete();
            repeat ($urandom_range(1, 16))
               sentence_bytes.push_back(8'($urandom_range(0, 255)));
         end else begin
            len = ($urandom_range(19) == 0) ? $urandom_range(0, 130) : $urandom_range(0, 24);
            start_sentence((pick < 19) ? 8'($urandom_range(0, 255)) : CHAR_DOLLAR,
                           random_header());
            add_body(len);
            close_sentence();
            if (pick >= 70) begin
               case ($urandom_range(5))
                  0: spoil_checksum();
                  1: repeat (3) void'(sentence_bytes.pop_back());
                  2: begin
                     len = $urandom_range(1, sentence_bytes.size());
                     while (sentence_bytes.size() > len)
                        void'(sentence_bytes.pop_back());
                  end
                  3: begin
                     p = $urandom_range(2, sentence_bytes.size() - 4);
                     sentence_bytes[p] = sentence_bytes[p] | 8'h80;
                  end
                  4: lower_digits();
                  default: repeat ($urandom_range(1, 4))
                     sentence_bytes.push_back(8'($urandom_range(0, 255)));
               endcase
            end
         end
         send_sentence();
         sent += sentence_bytes.size();
      end
      tx_quiet = 1'b0;
      rx_quiet = 1'b0;
   endtask

   // Result side: random stalls, or a long hold counted here.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_tready <= rx_quiet || $urandom_range(99) >= 30;
         end
      end
   end

   task automatic check_field(input string name, input logic [7:0] exp_val,
                              input logic [7:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s: expected %0h, got %0h", name, exp_val, act_val);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_verdicts.size() == 0) begin
            $error("result beat with no sentence pending: %h", rsp_tdata);
            failures++;
         end else begin
            want = pending_verdicts.pop_front();
            got  = rsp_tdata[22:0];
            check_field("sentence_ok", 8'(want.sentence_ok), 8'(got.sentence_ok));
            check_field("sentence_kind", 8'(want.sentence_kind), 8'(got.sentence_kind));
            check_field("last_good_kind", 8'(want.last_good_kind), 8'(got.last_good_kind));
            check_field("computed_sum", want.computed_sum, got.computed_sum);
            check_field("received_sum", want.received_sum, got.received_sum);
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("nmea_sentence_check_classify_core regression: fail");
      $finish;
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      clear_sentence_state();
      last_kind = KIND_OTHER;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_sentence_kinds();
      test_corner_cases();
      test_output_stall();
      test_random_traffic();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_verdicts.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (failures == 0)
         $display("nmea_sentence_check_classify_core regression: pass");
      else
         $display("nmea_sentence_check_classify_core regression: fail");
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/nsc_pkg.sv
rtl/nsc_parser.sv
rtl/nmea_sentence_check_classify_core.sv
rtl/nsc_checker.sv
test/tb_top.sv
